// File: sv/bpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_pkg
// Types and constants shared by the boot packet deframer modules.
// ----------------------------------------------------------------------------
package bpd_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'hAA;
    localparam logic [7:0] OPCODE_MIN  = 8'h01;
    localparam logic [7:0] OPCODE_MAX  = 8'h04;
    // bytes of framing ahead of the payload
    localparam int unsigned FRAME_OVERHEAD = 4;
    localparam int unsigned OUT_LEN_W      = 12;

    typedef enum logic [3:0] {
        EV_DROP     = 4'd0,
        EV_HEADER   = 4'd1,
        EV_OP_OK    = 4'd2,
        EV_LEN_LO   = 4'd3,
        EV_LEN_OK   = 4'd4,
        EV_PAYLOAD  = 4'd5,
        EV_COMPLETE = 4'd6,
        EV_BAD_OP   = 4'd7,
        EV_TOO_LONG = 4'd8
    } event_t;

    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_OPCODE  = 5'b00010,
        PH_LEN_LO  = 5'b00100,
        PH_LEN_HI  = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        event_t                 event_res;
        logic [7:0]             data_byte;
        logic [2:0]             opcode;
        logic [OUT_LEN_W-1:0]   pkt_length;
        logic [OUT_LEN_W-1:0]   payload_index;
    } res_item_t;

endpackage

// File: sv/bpd_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_stream_if
// Valid/ready stream channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface bpd_stream_if #(
    parameter type payload_t = logic [7:0]
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// File: sv/bpd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_in_stage
// Input register: captures one received byte and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module bpd_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    bpd_stream_if.sink    rx,
    input  logic          advance,
    output logic          held_valid,
    output logic [7:0]    held_byte
);
    import bpd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       take;

    assign rx.ready   = !valid_reg || advance;
    assign take       = rx.valid && rx.ready;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);
    assign byte_next  = take ? rx.payload.rx_byte : byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

// File: sv/bpd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_parser
// Framing state and per-byte classification of header, opcode, length and
// payload bytes.
// ----------------------------------------------------------------------------
module bpd_parser #(
    parameter int unsigned PACKET_MAX = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    output bpd_pkg::res_item_t   result
);
    import bpd_pkg::*;

    localparam int unsigned LEN_W     = $clog2(PACKET_MAX);
    localparam logic [16:0] LEN_LIMIT = 17'(PACKET_MAX - FRAME_OVERHEAD);

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [LEN_W-1:0]   taken_reg;
    logic [LEN_W-1:0]   taken_next;
    logic [7:0]         len_lo_reg;
    logic [7:0]         len_lo_next;
    logic [LEN_W-1:0]   held_len_reg;
    logic [LEN_W-1:0]   held_len_next;
    logic [2:0]         held_op_reg;
    logic [2:0]         held_op_next;

    logic [15:0]        len_rx;
    logic [LEN_W-1:0]   taken_inc;
    logic [31:0]        held_len_wide;
    logic [31:0]        taken_wide;

    assign len_rx        = {rx_byte, len_lo_reg};
    assign taken_inc     = taken_reg + LEN_W'(1);
    assign held_len_wide = 32'(held_len_reg);
    assign taken_wide    = 32'(taken_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        taken_next    = taken_reg;
        len_lo_next   = len_lo_reg;
        held_len_next = held_len_reg;
        held_op_next  = held_op_reg;

        result.event_res      = EV_DROP;
        result.data_byte      = rx_byte;
        result.opcode         = '0;
        result.pkt_length     = '0;
        result.payload_index  = '0;

        unique case (phase_reg)
            PH_OPCODE:
            begin
                if (rx_byte >= OPCODE_MIN && rx_byte <= OPCODE_MAX)
                begin
                    held_op_next     = rx_byte[2:0];
                    result.opcode    = rx_byte[2:0];
                    result.event_res = EV_OP_OK;
                    phase_next       = PH_LEN_LO;
                end
                else
                begin
                    result.event_res = EV_BAD_OP;
                    phase_next       = PH_HUNT;
                    taken_next       = '0;
                    len_lo_next      = '0;
                    held_len_next    = '0;
                    held_op_next     = '0;
                end
            end
            PH_LEN_LO:
            begin
                len_lo_next      = rx_byte;
                result.opcode    = held_op_reg;
                result.event_res = EV_LEN_LO;
                phase_next       = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                result.opcode = held_op_reg;
                if ({1'b0, len_rx} > LEN_LIMIT || len_rx == 16'd0)
                begin
                    // zero length completes right here
                    result.event_res = (len_rx == 16'd0) ? EV_COMPLETE : EV_TOO_LONG;
                    phase_next       = PH_HUNT;
                    taken_next       = '0;
                    len_lo_next      = '0;
                    held_len_next    = '0;
                    held_op_next     = '0;
                end
                else
                begin
                    held_len_next         = len_rx[LEN_W-1:0];
                    result.pkt_length     = len_rx[OUT_LEN_W-1:0];
                    taken_next            = '0;
                    result.event_res      = EV_LEN_OK;
                    phase_next            = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                result.opcode         = held_op_reg;
                result.pkt_length     = held_len_wide[OUT_LEN_W-1:0];
                result.payload_index  = taken_wide[OUT_LEN_W-1:0];
                if (taken_inc >= held_len_reg)
                begin
                    result.event_res = EV_COMPLETE;
                    phase_next       = PH_HUNT;
                    taken_next       = '0;
                    len_lo_next      = '0;
                    held_len_next    = '0;
                    held_op_next     = '0;
                end
                else
                begin
                    result.event_res = EV_PAYLOAD;
                    taken_next       = taken_inc;
                end
            end
            default:
            begin
                if (rx_byte == HEADER_BYTE)
                begin
                    result.event_res = EV_HEADER;
                    phase_next       = PH_OPCODE;
                    held_op_next     = '0;
                    held_len_next    = '0;
                    taken_next       = '0;
                end
                else
                begin
                    result.event_res = EV_DROP;
                    phase_next       = PH_HUNT;
                    taken_next       = '0;
                    len_lo_next      = '0;
                    held_len_next    = '0;
                    held_op_next     = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            taken_reg    <= '0;
            len_lo_reg   <= '0;
            held_len_reg <= '0;
            held_op_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            taken_reg    <= taken_next;
            len_lo_reg   <= len_lo_next;
            held_len_reg <= held_len_next;
            held_op_reg  <= held_op_next;
        end
    end

    // payload phase always has bytes left to take
    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> taken_reg < held_len_reg)
        else $error("payload phase with no bytes left");

    // hunting holds no packet context
    a_hunt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HUNT |-> (held_op_reg == 3'd0 && held_len_reg == '0))
        else $error("packet context kept while hunting");

    // once past the opcode, the held opcode is a legal one
    a_op_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEN_LO || phase_reg == PH_LEN_HI || phase_reg == PH_PAYLOAD)
        |-> (held_op_reg >= 3'd1 && held_op_reg <= 3'd4))
        else $error("illegal opcode held");

    // a completion always sends the parser back to hunting
    a_done_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.event_res == EV_COMPLETE |=> phase_reg == PH_HUNT)
        else $error("no return to hunting after completion");

endmodule

// File: sv/bpd_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_out_stage
// Result register: holds one classified byte until the consumer takes it.
// ----------------------------------------------------------------------------
module bpd_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  bpd_pkg::res_item_t   result,
    output logic                 space,
    bpd_stream_if.source         res
);
    import bpd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    res_item_t item_reg;
    res_item_t item_next;

    assign space      = !valid_reg || res.ready;
    assign valid_next = load ? 1'b1 : (res.ready ? 1'b0 : valid_reg);
    assign item_next  = load ? result : item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign res.valid   = valid_reg;
    assign res.payload = item_reg;

endmodule

// File: sv/boot_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boot_packet_deframer
// Deframes bootloader packets (header, opcode, 16-bit length, payload) one
// received byte at a time and emits one classified result per byte.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                         transaction
//  rx       in   rx_item_t  {rx_byte}                            valid & ready
//  res      out  res_item_t {event_res, data_byte, opcode,       valid & ready
//                            pkt_length, payload_index}
//
//  one byte per cycle sustained while res is ready; each byte goes from rx to res
//  through the input register, then the parser decision into the result register
//  the framing state advances once per byte moved into the result register
//  rst_n clears the valid flags and parser state asynchronously; the parser starts out hunting
//  a stalled res holds its result while one more byte waits in the input register
// ----------------------------------------------------------------------------
module boot_packet_deframer #(
    parameter int unsigned PACKET_MAX = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    bpd_stream_if.sink    rx,
    bpd_stream_if.source  res
);
    import bpd_pkg::*;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       space;
    logic       advance;
    res_item_t  result;

    assign advance = held_valid && space;

    bpd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    bpd_parser #(
        .PACKET_MAX (PACKET_MAX)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (held_byte),
        .result  (result)
    );

    bpd_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .result (result),
        .space  (space),
        .res    (res)
    );

endmodule
